// ===== rtl/core/hsv_pkg.sv =====
// hsv_pkg: types and constants for the hsv to rgb converter
// used by hsv_to_rgb
package hsv_pkg;

	localparam int unsigned HueW  = 9;
	localparam int unsigned PctW  = 7;
	localparam int unsigned ChanW = 8;

	// valid input limits
	localparam logic [HueW-1:0] HueMax = 9'd360;
	localparam logic [PctW-1:0] PctMax = 7'd100;

	// exact numerators are over 600000, 20 bits hold the largest one
	localparam int unsigned NumW  = 20;
	localparam int unsigned ProdW = 14;

	// floor(255 * n / 600000) = floor(n * 17 / 40000), done as
	// floor(n * 17 * ceil(2^40 / 40000) / 2^40), exact for n <= 600000
	localparam int unsigned DivShift = 40;
	localparam int unsigned DivMulW  = 29;
	localparam logic [DivMulW-1:0] DivMul = 29'd467292447;
	localparam int unsigned DivProdW = NumW + DivMulW;

	// 60 degree hue sector
	typedef enum logic [2:0] {
		SEC_RY,
		SEC_YG,
		SEC_GC,
		SEC_CB,
		SEC_BM,
		SEC_MR
	} sector_t;

endpackage

// ===== rtl/core/hsv_to_rgb.sv =====
// hsv_to_rgb: five stage pipelined hsv to rgb colour converter
// one request per cycle sustained while rgb_ready stays high
// the stage depth is set by the exact divide by 600000 done as a constant multiply in stage 5
// every stage has its own valid bit and stalls only when the stage after it is full
// arst_n clears all valid bits, data registers are not reset
// depends on hsv_pkg
module hsv_to_rgb (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hsv_valid,
	output logic       hsv_ready,
	input  logic [8:0] hue,
	input  logic [6:0] saturation,
	input  logic [6:0] brightness,
	output logic       rgb_valid,
	input  logic       rgb_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       range_error
);

	// stage enables: a stage loads when it is empty or its content moves on
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !vld_s5 || rgb_ready;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign hsv_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= hsv_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: range check, hue sector and distance from sector middle
	// ---------------------------------------------------------------
	logic                 err_c;
	hsv_pkg::sector_t     sec_c;
	logic [6:0]           t_c;     // hue mod 120
	logic [5:0]           dist_c;  // |t - 60|

	always_comb begin
		err_c = (hue > hsv_pkg::HueMax) || (saturation > hsv_pkg::PctMax) ||
			(brightness > hsv_pkg::PctMax);

		if (hue < 9'd60)       sec_c = hsv_pkg::SEC_RY;
		else if (hue < 9'd120) sec_c = hsv_pkg::SEC_YG;
		else if (hue < 9'd180) sec_c = hsv_pkg::SEC_GC;
		else if (hue < 9'd240) sec_c = hsv_pkg::SEC_CB;
		else if (hue < 9'd300) sec_c = hsv_pkg::SEC_BM;
		else                   sec_c = hsv_pkg::SEC_MR;

		// hue of exactly 360 folds to zero and stays in the last sector
		if (hue < 9'd120)      t_c = hue[6:0];
		else if (hue < 9'd240) t_c = 7'(hue - 9'd120);
		else if (hue < 9'd360) t_c = 7'(hue - 9'd240);
		else                   t_c = 7'(hue - 9'd360);

		dist_c = (t_c >= 7'd60) ? 6'(t_c - 7'd60) : 6'(7'd60 - t_c);
	end

	logic             err_s1;
	hsv_pkg::sector_t sec_s1;
	logic [5:0]       wgt_s1;   // 60 - dist, weight of the secondary component
	logic [6:0]       sat_s1, val_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			err_s1 <= err_c;
			sec_s1 <= sec_c;
			wgt_s1 <= 6'(6'd60 - dist_c);
			sat_s1 <= saturation;
			val_s1 <= brightness;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: s*v and v*(100-s), forced to zero on a range error
	// so every later numerator is zero as well
	// ---------------------------------------------------------------
	logic [hsv_pkg::ProdW-1:0] sv_c, vm_c;
	logic [6:0]                inv_sat_c;

	always_comb begin
		inv_sat_c = 7'(hsv_pkg::PctMax - sat_s1);
		if (err_s1) begin
			sv_c = '0;
			vm_c = '0;
		end else begin
			sv_c = hsv_pkg::ProdW'(sat_s1) * hsv_pkg::ProdW'(val_s1);
			vm_c = hsv_pkg::ProdW'(val_s1) * hsv_pkg::ProdW'(inv_sat_c);
		end
	end

	logic                      err_s2;
	hsv_pkg::sector_t          sec_s2;
	logic [5:0]                wgt_s2;
	logic [hsv_pkg::ProdW-1:0] sv_s2, vm_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			err_s2 <= err_s1;
			sec_s2 <= sec_s1;
			wgt_s2 <= wgt_s1;
			sv_s2  <= sv_c;
			vm_s2  <= vm_c;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: chroma, secondary and offset numerators over 600000
	// ---------------------------------------------------------------
	logic                     err_s3;
	hsv_pkg::sector_t         sec_s3;
	logic [hsv_pkg::NumW-1:0] chr_s3, sec_n_s3, ofs_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			err_s3   <= err_s2;
			sec_s3   <= sec_s2;
			chr_s3   <= hsv_pkg::NumW'(sv_s2) * hsv_pkg::NumW'(6'd60);
			sec_n_s3 <= hsv_pkg::NumW'(sv_s2) * hsv_pkg::NumW'(wgt_s2);
			ofs_s3   <= hsv_pkg::NumW'(vm_s2) * hsv_pkg::NumW'(6'd60);
		end
	end

	// ---------------------------------------------------------------
	// stage 4: sector ordering and offset add
	// c + m is 6000*v at most, so the sums stay within 20 bits
	// ---------------------------------------------------------------
	logic [hsv_pkg::NumW-1:0] r_c, g_c, b_c;

	always_comb begin
		case (sec_s3)
			hsv_pkg::SEC_RY: begin r_c = chr_s3;   g_c = sec_n_s3; b_c = '0;       end
			hsv_pkg::SEC_YG: begin r_c = sec_n_s3; g_c = chr_s3;   b_c = '0;       end
			hsv_pkg::SEC_GC: begin r_c = '0;       g_c = chr_s3;   b_c = sec_n_s3; end
			hsv_pkg::SEC_CB: begin r_c = '0;       g_c = sec_n_s3; b_c = chr_s3;   end
			hsv_pkg::SEC_BM: begin r_c = sec_n_s3; g_c = '0;       b_c = chr_s3;   end
			default:         begin r_c = chr_s3;   g_c = '0;       b_c = sec_n_s3; end
		endcase
	end

	logic                     err_s4;
	logic [hsv_pkg::NumW-1:0] r_s4, g_s4, b_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			err_s4 <= err_s3;
			r_s4   <= r_c + ofs_s3;
			g_s4   <= g_c + ofs_s3;
			b_s4   <= b_c + ofs_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: floor(255 * n / 600000) by reciprocal multiply
	// ---------------------------------------------------------------
	logic [hsv_pkg::DivProdW-1:0] r_p, g_p, b_p;

	assign r_p = hsv_pkg::DivProdW'(r_s4) * hsv_pkg::DivProdW'(hsv_pkg::DivMul);
	assign g_p = hsv_pkg::DivProdW'(g_s4) * hsv_pkg::DivProdW'(hsv_pkg::DivMul);
	assign b_p = hsv_pkg::DivProdW'(b_s4) * hsv_pkg::DivProdW'(hsv_pkg::DivMul);

	logic       err_s5;
	logic [7:0] red_s5, green_s5, blue_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			err_s5   <= err_s4;
			red_s5   <= r_p[hsv_pkg::DivShift +: hsv_pkg::ChanW];
			green_s5 <= g_p[hsv_pkg::DivShift +: hsv_pkg::ChanW];
			blue_s5  <= b_p[hsv_pkg::DivShift +: hsv_pkg::ChanW];
		end
	end

	assign rgb_valid   = vld_s5;
	assign red         = red_s5;
	assign green       = green_s5;
	assign blue        = blue_s5;
	assign range_error = err_s5;

endmodule

// ===== rtl/core/hsv_chk.sv =====
// hsv_props: port level checks for hsv_to_rgb, bound into every hsv_to_rgb instance
// depends on hsv_to_rgb ports only
module hsv_props (
	input logic       clk,
	input logic       arst_n,
	input logic       hsv_valid,
	input logic       hsv_ready,
	input logic [8:0] hue,
	input logic [6:0] saturation,
	input logic [6:0] brightness,
	input logic       rgb_valid,
	input logic       rgb_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       range_error
);

	// an error result carries a black colour
	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && range_error |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("range error result with nonzero colour");

	// with the output free the pipeline always takes a request
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_valid || rgb_ready |-> hsv_ready)
		else $error("request refused while output is free");

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid)
		else $error("result dropped under stall");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> $stable(red) && $stable(green) && $stable(blue) &&
			$stable(range_error))
		else $error("result changed under stall");

endmodule

bind hsv_to_rgb hsv_props u_hsv_props (.*);
